// File: rtl/pdpc_pkg.sv
// Shared types, codes and helpers for the packet deframer with popcount check.
// No dependencies; used by packet_deframer_popcount_check_core.
package pdpc_pkg;

    // Header layout.
    localparam logic [7:0] HDR_BYTES   = 8'd4;
    localparam logic [7:0] MIN_LENGTH  = 8'd5;
    localparam logic [7:0] POS_COUNT_LO = 8'd0;
    localparam logic [7:0] POS_COUNT_HI = 8'd1;
    localparam logic [7:0] POS_FLAGS    = 8'd2;
    localparam logic [7:0] POS_LENGTH   = 8'd3;

    // Decoded command codes.
    localparam logic [1:0] CMD_DRIVE    = 2'd0;
    localparam logic [1:0] CMD_SLEEP    = 2'd1;
    localparam logic [1:0] CMD_RESPONSE = 2'd2;

    // Summary result codes.
    localparam logic [1:0] RES_OK       = 2'd0;
    localparam logic [1:0] RES_MISMATCH = 2'd1;
    localparam logic [1:0] RES_LEN_ERR  = 2'd2;

    // One result item as it leaves the block.
    typedef struct packed {
        logic        last;
        logic [7:0]  body_byte;
        logic [15:0] pkt_count;
        logic        flag_drive;
        logic        flag_status;
        logic        flag_sleep;
        logic        flag_ack;
        logic [3:0]  padding_bits;
        logic [7:0]  total_length;
        logic [1:0]  command;
        logic [1:0]  result_code;
    } t_result;

    // Number of one bits in a byte.
    function automatic logic [3:0] ones_in(input logic [7:0] v);
        logic [3:0] n;
        n = 4'd0;
        for (int k = 0; k < 8; k++) begin
            n = n + {3'd0, v[k]};
        end
        return n;
    endfunction

    // Build a packet summary from the stored header.
    function automatic t_result make_summary(
        input logic [15:0] count,
        input logic [7:0]  flags,
        input logic [7:0]  len_field,
        input logic [1:0]  code
    );
        t_result r;
        r              = '0;
        r.last         = 1'b1;
        r.pkt_count    = count;
        r.flag_drive   = flags[7];
        r.flag_status  = flags[6];
        r.flag_sleep   = flags[5];
        r.flag_ack     = flags[4];
        r.padding_bits = flags[3:0];
        r.total_length = len_field;
        if (flags[6]) begin
            r.command = CMD_RESPONSE;
        end else if (flags[5]) begin
            r.command = CMD_SLEEP;
        end else begin
            r.command = CMD_DRIVE;
        end
        r.result_code  = code;
        return r;
    endfunction

endpackage

// File: rtl/packet_deframer_popcount_check_core.sv
// Packet deframer core: header capture, popcount check and result buffering.
// Depends on pdpc_pkg for the result type, codes and helper functions.
//
// A result is registered in the output register, or in the skid register on a stall.
// Throughput: one request per cycle while the skid register is empty; a two-entry
// output buffer (output register plus skid register) lets a request be taken while
// a result still waits downstream. Reset (synchronous, active low) clears the byte
// position, running bit sum, header registers and both output valid flags.
module packet_deframer_popcount_check_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request channel
    input  logic        i_rx_valid,
    output logic        o_rx_stall,
    input  logic [7:0]  i_rx_byte,
    // Result channel
    output logic        o_res_valid,
    input  logic        i_res_stall,
    output logic        o_last,
    output logic [7:0]  o_body_byte,
    output logic [15:0] o_pkt_count,
    output logic        o_flag_drive,
    output logic        o_flag_status,
    output logic        o_flag_sleep,
    output logic        o_flag_ack,
    output logic [3:0]  o_padding_bits,
    output logic [7:0]  o_total_length,
    output logic [1:0]  o_command,
    output logic [1:0]  o_result_code
);

    // Deframer state.
    logic [7:0]  r_pos,    n_pos;
    logic [7:0]  r_sum,    n_sum;
    logic [15:0] r_count,  n_count;
    logic [7:0]  r_flags,  n_flags;
    logic [7:0]  r_length, n_length;

    // Output buffering.
    logic                 r_out_valid;
    logic                 r_skid_valid;
    pdpc_pkg::t_result    r_out;
    pdpc_pkg::t_result    r_skid;

    logic                 in_fire;
    logic                 out_free;
    logic                 res_valid;
    pdpc_pkg::t_result    res;
    logic [7:0]           byte_sum;
    logic [8:0]           pos_plus1;

    // A request is taken whenever the skid register is empty.
    assign o_rx_stall = r_skid_valid;
    assign in_fire    = i_rx_valid && !r_skid_valid;
    assign out_free   = !r_out_valid || !i_res_stall;

    assign byte_sum  = r_sum + {4'd0, pdpc_pkg::ones_in(i_rx_byte)};
    assign pos_plus1 = {1'b0, r_pos} + 9'd1;

    // Per-byte deframing and check.
    always_comb begin
        n_pos     = r_pos;
        n_sum     = r_sum;
        n_count   = r_count;
        n_flags   = r_flags;
        n_length  = r_length;
        res_valid = 1'b0;
        res       = '0;
        if (in_fire) begin
            if (r_pos < pdpc_pkg::HDR_BYTES) begin
                // Header byte: capture the field and keep counting bits.
                unique case (r_pos[1:0])
                    pdpc_pkg::POS_COUNT_LO[1:0]: n_count[7:0]  = i_rx_byte;
                    pdpc_pkg::POS_COUNT_HI[1:0]: n_count[15:8] = i_rx_byte;
                    pdpc_pkg::POS_FLAGS[1:0]:    n_flags       = i_rx_byte;
                    default:                     n_length      = i_rx_byte;
                endcase
                n_sum = byte_sum;
                n_pos = pos_plus1[7:0];
                if (r_pos == pdpc_pkg::POS_LENGTH && i_rx_byte < pdpc_pkg::MIN_LENGTH) begin
                    // Short packet: report a length error and restart.
                    res_valid = 1'b1;
                    res       = pdpc_pkg::make_summary(r_count, r_flags, 8'd0,
                                                       pdpc_pkg::RES_LEN_ERR);
                    n_pos     = 8'd0;
                    n_sum     = 8'd0;
                end
            end else if (pos_plus1 >= {1'b0, r_length}) begin
                // Check byte: compare against the running bit count.
                res_valid = 1'b1;
                res       = pdpc_pkg::make_summary(r_count, r_flags, r_length,
                                (i_rx_byte == r_sum) ? pdpc_pkg::RES_OK
                                                     : pdpc_pkg::RES_MISMATCH);
                n_pos     = 8'd0;
                n_sum     = 8'd0;
            end else begin
                // Body byte: pass it on.
                res_valid     = 1'b1;
                res.body_byte = i_rx_byte;
                n_sum         = byte_sum;
                n_pos         = pos_plus1[7:0];
            end
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= 8'd0;
            r_sum    <= 8'd0;
            r_count  <= 16'd0;
            r_flags  <= 8'd0;
            r_length <= 8'd0;
        end else begin
            r_pos    <= n_pos;
            r_sum    <= n_sum;
            r_count  <= n_count;
            r_flags  <= n_flags;
            r_length <= n_length;
        end
    end

    // Output register with skid stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= res_valid;
            end
        end else if (res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (res_valid) begin
                r_out <= res;
            end
        end else if (res_valid) begin
            r_skid <= res;
        end
    end

    // Result ports.
    assign o_res_valid    = r_out_valid;
    assign o_last         = r_out.last;
    assign o_body_byte    = r_out.body_byte;
    assign o_pkt_count    = r_out.pkt_count;
    assign o_flag_drive   = r_out.flag_drive;
    assign o_flag_status  = r_out.flag_status;
    assign o_flag_sleep   = r_out.flag_sleep;
    assign o_flag_ack     = r_out.flag_ack;
    assign o_padding_bits = r_out.padding_bits;
    assign o_total_length = r_out.total_length;
    assign o_command      = r_out.command;
    assign o_result_code  = r_out.result_code;

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for packet_deframer_popcount_check_core: random and directed
// byte streams against a scoreboard that predicts body bytes and packet summaries.
// Depends on pdpc_pkg and the core RTL only.
module testbench;

    // Predicts the results of the deframer and checks what comes out of it.
    class frame_scoreboard;
        logic [7:0]  position;
        logic [7:0]  ones_total;
        logic [15:0] count_hdr;
        logic [7:0]  flags_hdr;
        logic [7:0]  length_hdr;
        pdpc_pkg::t_result expected_q[$];
        int          errors;
        int          bodies_seen;
        int          ok_seen;
        int          bad_check_seen;
        int          len_err_seen;

        function new();
            position   = '0;
            ones_total = '0;
            count_hdr  = '0;
            flags_hdr  = '0;
            length_hdr = '0;
            errors     = 0;
        endfunction

        static function logic [3:0] bit_weight(logic [7:0] v);
            logic [3:0] n;
            n = '0;
            foreach (v[k]) n = n + 4'(v[k]);
            return n;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Summary built from the captured header fields.
        function pdpc_pkg::t_result summary(logic [7:0] len_field, logic [1:0] code);
            pdpc_pkg::t_result r;
            r              = '0;
            r.last         = 1'b1;
            r.pkt_count    = count_hdr;
            r.flag_drive   = flags_hdr[7];
            r.flag_status  = flags_hdr[6];
            r.flag_sleep   = flags_hdr[5];
            r.flag_ack     = flags_hdr[4];
            r.padding_bits = flags_hdr[3:0];
            r.total_length = len_field;
            r.command      = flags_hdr[6] ? pdpc_pkg::CMD_RESPONSE :
                             (flags_hdr[5] ? pdpc_pkg::CMD_SLEEP : pdpc_pkg::CMD_DRIVE);
            r.result_code  = code;
            return r;
        endfunction

        // Advance the predicted deframer by one accepted request byte.
        function void note_request(logic [7:0] b);
            pdpc_pkg::t_result r;
            if (position < pdpc_pkg::HDR_BYTES) begin
                case (position)
                    pdpc_pkg::POS_COUNT_LO: count_hdr[7:0]  = b;
                    pdpc_pkg::POS_COUNT_HI: count_hdr[15:8] = b;
                    pdpc_pkg::POS_FLAGS:    flags_hdr       = b;
                    default:                length_hdr      = b;
                endcase
                ones_total = ones_total + {4'd0, bit_weight(b)};
                if (position == pdpc_pkg::POS_LENGTH && length_hdr < pdpc_pkg::MIN_LENGTH) begin
                    expected_q.push_back(summary(8'd0, pdpc_pkg::RES_LEN_ERR));
                    position   = '0;
                    ones_total = '0;
                end else begin
                    position = position + 8'd1;
                end
            end else if ({1'b0, position} + 9'd1 >= {1'b0, length_hdr}) begin
                // Check byte closes the packet.
                expected_q.push_back(summary(length_hdr,
                                             (b == ones_total) ? pdpc_pkg::RES_OK
                                                               : pdpc_pkg::RES_MISMATCH));
                position   = '0;
                ones_total = '0;
            end else begin
                r           = '0;
                r.body_byte = b;
                expected_q.push_back(r);
                ones_total = ones_total + {4'd0, bit_weight(b)};
                position   = position + 8'd1;
            end
        endfunction

        task report_mismatch(string what);
            errors++;
            $display("MISMATCH: %s", what);
        endtask

        task check_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
        endtask

        // Compare one accepted result with the oldest prediction.
        task check_result(pdpc_pkg::t_result got);
            pdpc_pkg::t_result want;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result last=%0b body=%02h",
                                          got.last, got.body_byte));
                return;
            end
            want = expected_q.pop_front();
            check_field("last", 16'(got.last), 16'(want.last));
            check_field("body_byte", 16'(got.body_byte), 16'(want.body_byte));
            check_field("pkt_count", got.pkt_count, want.pkt_count);
            check_field("flag_drive", 16'(got.flag_drive), 16'(want.flag_drive));
            check_field("flag_status", 16'(got.flag_status), 16'(want.flag_status));
            check_field("flag_sleep", 16'(got.flag_sleep), 16'(want.flag_sleep));
            check_field("flag_ack", 16'(got.flag_ack), 16'(want.flag_ack));
            check_field("padding_bits", 16'(got.padding_bits), 16'(want.padding_bits));
            check_field("total_length", 16'(got.total_length), 16'(want.total_length));
            check_field("command", 16'(got.command), 16'(want.command));
            check_field("result_code", 16'(got.result_code), 16'(want.result_code));
            if (!want.last) bodies_seen++;
            else if (want.result_code == pdpc_pkg::RES_OK) ok_seen++;
            else if (want.result_code == pdpc_pkg::RES_MISMATCH) bad_check_seen++;
            else len_err_seen++;
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        rx_valid = 1'b0;
    logic [7:0]  rx_byte = '0;
    logic        rx_stall;
    logic        res_valid;
    logic        res_stall = 1'b0;
    pdpc_pkg::t_result observed;
    bit          no_idle = 1'b0;
    int          requests_sent = 0;
    int          stall_left = 0;
    frame_scoreboard sb;

    packet_deframer_popcount_check_core dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_rx_valid     (rx_valid),
        .o_rx_stall     (rx_stall),
        .i_rx_byte      (rx_byte),
        .o_res_valid    (res_valid),
        .i_res_stall    (res_stall),
        .o_last         (observed.last),
        .o_body_byte    (observed.body_byte),
        .o_pkt_count    (observed.pkt_count),
        .o_flag_drive   (observed.flag_drive),
        .o_flag_status  (observed.flag_status),
        .o_flag_sleep   (observed.flag_sleep),
        .o_flag_ack     (observed.flag_ack),
        .o_padding_bits (observed.padding_bits),
        .o_total_length (observed.total_length),
        .o_command      (observed.command),
        .o_result_code  (observed.result_code)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side: check each accepted result, then stall for a random stretch.
    always @(posedge clk) begin
        if (rst_n) begin
            if (res_stall) begin
                stall_left = stall_left - 1;
                if (stall_left == 0) res_stall <= 1'b0;
            end else if (res_valid) begin
                sb.check_result(observed);
                stall_left = no_idle ? 0 : $urandom_range(0, 4);
                if (stall_left > 0) res_stall <= 1'b1;
            end
        end
    end

    // Offer one request byte after a random gap and hold it until it is taken.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            rx_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (rx_stall) @(posedge clk);
        sb.note_request(b);
        requests_sent++;
    endtask

    // Send a whole packet; a corrupt packet gets one bit of its check byte flipped.
    task automatic send_frame(input logic [15:0] count, input logic [7:0] flags,
                              input logic [7:0] len, input bit corrupt);
        logic [7:0] ones;
        logic [7:0] b;
        ones = '0;
        ones = ones + 8'(frame_scoreboard::bit_weight(count[7:0]));
        ones = ones + 8'(frame_scoreboard::bit_weight(count[15:8]));
        ones = ones + 8'(frame_scoreboard::bit_weight(flags));
        ones = ones + 8'(frame_scoreboard::bit_weight(len));
        send_byte(count[7:0]);
        send_byte(count[15:8]);
        send_byte(flags);
        send_byte(len);
        if (len < pdpc_pkg::MIN_LENGTH) return;
        for (int k = 0; k < int'(len) - int'(pdpc_pkg::MIN_LENGTH); k++) begin
            b    = 8'($urandom_range(0, 255));
            ones = ones + 8'(frame_scoreboard::bit_weight(b));
            send_byte(b);
        end
        if (corrupt) ones = ones ^ (8'd1 << $urandom_range(0, 7));
        send_byte(ones);
    endtask

    // Hold off new requests until every predicted result has come out.
    task automatic wait_drained();
        rx_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
    endtask

    initial begin
        int  pick;
        bit  paused;
        sb     = new();
        paused = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed packets: header extremes, each command, each result code.
        send_frame(16'h0000, 8'h00, 8'd5, 1'b0);
        send_frame(16'hFFFF, 8'hFF, 8'd0, 1'b0);
        send_frame(16'h00FF, 8'h20, 8'd4, 1'b0);
        send_frame(16'hFF00, 8'h6F, 8'd6, 1'b1);
        send_frame(16'h8001, 8'h90, 8'd7, 1'b0);
        wait_drained();

        // Random packets, mostly well formed, with some noise and short lengths.
        while (requests_sent < 120) begin
            no_idle = ($urandom_range(0, 4) == 0);
            pick    = $urandom_range(0, 99);
            if (pick < 75) begin
                send_frame(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(5, 12)), $urandom_range(0, 3) == 0);
            end else if (pick < 85) begin
                send_frame(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 4)), 1'b0);
            end else if (pick < 92) begin
                send_frame(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(13, 40)), $urandom_range(0, 1) == 1);
            end else begin
                // Noise that breaks framing, then filler until a packet boundary.
                repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(0, 255)));
                while (sb.position != 0) send_byte(8'($urandom_range(0, 255)));
            end
            if (!paused && requests_sent >= 70) begin
                wait_drained();
                paused = 1'b1;
            end
        end
        no_idle = 1'b0;
        send_frame(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)), 8'd255, 1'b0);

        wait_drained();
        repeat (5) @(posedge clk);
        $display("Sent %0d request bytes; checked %0d body bytes and %0d summaries",
                 requests_sent, sb.bodies_seen,
                 sb.ok_seen + sb.bad_check_seen + sb.len_err_seen);
        $display("Summaries: %0d check ok, %0d check mismatch, %0d length error",
                 sb.ok_seen, sb.bad_check_seen, sb.len_err_seen);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2_000_000;
        $display("Timeout with %0d results outstanding", sb.pending());
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: files.f
rtl/pdpc_pkg.sv
rtl/packet_deframer_popcount_check_core.sv
bench/testbench.sv
